>>> src/ssel_pkg.sv
package ssel_pkg;

  localparam int TABLE_ENTRIES = 40;
  localparam int MAX_PER_LINE  = 10;
  localparam int TABLE_BYTES   = 4 * TABLE_ENTRIES;
  localparam int ID_W          = $clog2(TABLE_ENTRIES);
  localparam int IC_W          = $clog2(TABLE_ENTRIES + 1);
  localparam int CNT_W         = $clog2(MAX_PER_LINE + 1);

  localparam logic [7:0] LINE_BIAS     = 8'h10;
  localparam logic [7:0] CLASSIC_MASK  = 8'hF0;
  localparam logic [4:0] HEIGHT_SHORT  = 5'd8;
  localparam logic [4:0] HEIGHT_TALL   = 5'd16;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_SCAN  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] table_offset;
    logic [7:0] write_byte;
    logic [7:0] line_number;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       found;
    logic [5:0] sprite_index;
    logic [7:0] pos_y;
    logic [7:0] pos_x;
    logic [7:0] tile_number;
    logic [7:0] attribute_bits;
    logic [3:0] palette_number;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [7:0]      y;
    logic [7:0]      x;
    logic [7:0]      tile;
    logic [7:0]      attr;
  } pick_t;

  typedef struct packed {
    logic  v;
    pick_t p;
  } cell_t;

  typedef struct packed {
    cell_t c;
    logic  bef;
  } link_t;

endpackage

>>> src/ssel_table.sv
module ssel_table import ssel_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            we,
  input  logic [ID_W-1:0] w_idx,
  input  logic [1:0]      w_lane,
  input  logic [7:0]      w_byte,
  input  logic [ID_W-1:0] r_idx,
  output logic [31:0]     r_word
);

  logic [31:0]              mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld;
  logic [31:0]              r_raw;
  logic                     r_vld;

  // an entry never written reads as zero, so a first write clears the other lanes
  always_ff @(posedge clk) begin
    if (we) begin
      for (int k = 0; k < 4; k++) begin
        if (w_lane == 2'(k)) begin
          mem[w_idx][8*k +: 8] <= w_byte;
        end else if (!vld[w_idx]) begin
          mem[w_idx][8*k +: 8] <= 8'h00;
        end
      end
    end
    r_raw <= mem[r_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      r_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[w_idx] <= 1'b1;
      end
      r_vld <= vld[r_idx];
    end
  end

  assign r_word = r_vld ? r_raw : 32'h0;

endmodule

>>> src/ssel_cell.sv
module ssel_cell import ssel_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  clear,
  input  logic  ins,
  input  logic  shl,
  input  logic  classic,
  input  pick_t new_pick,
  input  link_t prev,
  input  cell_t next,
  output link_t own
);

  cell_t c;
  cell_t c_next;
  logic  bef;

  // ids arrive in ascending order, so an x tie never moves the new pick ahead
  assign bef = c.v && classic && (new_pick.x < c.p.x);
  assign own = '{c: c, bef: bef};

  always_comb begin
    c_next = c;
    if (clear) begin
      c_next.v = 1'b0;
    end else if (ins) begin
      if (prev.c.v && prev.bef) begin
        c_next = prev.c;
      end else if (prev.c.v && (!c.v || bef)) begin
        c_next = '{v: 1'b1, p: new_pick};
      end
    end else if (shl) begin
      c_next = next;
    end
  end

  always_ff @(posedge clk) begin
    c.p <= c_next.p;
    if (rst) begin
      c.v <= 1'b0;
    end else begin
      c.v <= c_next.v;
    end
  end

endmodule

>>> src/scanline_sprite_select_top.sv
// Scanline sprite selector with a 40-entry sprite attribute table.
// Commands enter on command when start is high and busy is low. A read
// returns one result, a write none, a scan one result per picked sprite
// (up to 10, sorted by x in classic mode) or one empty result.
// Results appear on result for exactly one cycle with result_valid high;
// the receiver cannot stall, every result is taken as shown.
// A write completes on accept. A read registers the table word, then the
// result. A scan reads one table entry a cycle from the table's single
// read port, walking the table fully or stopping once the tenth pick is
// found, then emits its results back to back. Picks are sorted by x in
// classic mode only, on the fly in a row of 10 cells, so no sort pass.
// busy is high from accept until the last result is registered (reads, scans).
// color_mode and tall_sprites sit on the APB port (offsets 0 and 4); the user
// must see they are written only while idle, as the block does not enforce it.
// Reset clears the table (it reads as zero), the config registers and the
// control state; no clearing pass is needed.
module scanline_sprite_select_top import ssel_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_t        command,
  output logic        result_valid,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic             color_mode, tall_sprites;
  logic [IC_W-1:0]  issue_id;
  logic             pend;
  logic [ID_W-1:0]  pend_id;
  logic [7:0]       line;
  logic [1:0]       lane;
  logic             in_range_q;
  logic [CNT_W-1:0] count;

  logic             accept, in_range, issuing, we, hit, ins, shl, clear;
  logic [ID_W-1:0]  r_idx;
  logic [31:0]      r_word;
  logic [9:0]       offs;
  logic [4:0]       height;
  pick_t            new_pick;
  result_t          res_next;
  logic [7:0]       attr;
  link_t            links [MAX_PER_LINE];
  link_t            prev_l [MAX_PER_LINE];
  cell_t            next_c [MAX_PER_LINE];

  assign pready = 1'b1;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign prdata = paddr[2] ? {31'h0, tall_sprites} : {31'h0, color_mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode   <= 1'b0;
      tall_sprites <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        tall_sprites <= pwdata[0];
      end else begin
        color_mode <= pwdata[0];
      end
    end
  end

  assign in_range = ({1'b0, command.table_offset} < 9'(TABLE_BYTES));
  assign issuing  = (state == S_SCAN) && (issue_id != IC_W'(TABLE_ENTRIES));
  assign we       = accept && (command.operation == OP_WRITE) && in_range;
  assign r_idx    = issuing  ? issue_id[ID_W-1:0] :
                    in_range ? command.table_offset[ID_W+1:2] : '0;

  ssel_table u_table (
    .clk    (clk),
    .rst    (rst),
    .we     (we),
    .w_idx  (command.table_offset[ID_W+1:2]),
    .w_lane (command.table_offset[1:0]),
    .w_byte (command.write_byte),
    .r_idx  (r_idx),
    .r_word (r_word)
  );

  // line offset = line - y + 16, signed over 10 bits
  assign offs   = {2'b00, line} + {2'b00, LINE_BIAS} - {2'b00, r_word[7:0]};
  assign height = tall_sprites ? HEIGHT_TALL : HEIGHT_SHORT;
  assign hit    = !offs[9] && (offs[8:0] < {4'h0, height});
  assign ins    = (state == S_SCAN) && pend && hit && (count != CNT_W'(MAX_PER_LINE));
  assign clear  = accept && (command.operation == OP_SCAN);
  assign shl    = (state == S_EMIT) && (count != '0);

  assign new_pick = '{id: pend_id, y: r_word[7:0], x: r_word[15:8],
                      tile: r_word[23:16], attr: r_word[31:24]};

  always_comb begin
    for (int i = 0; i < MAX_PER_LINE; i++) begin
      if (i == 0) begin
        prev_l[i] = '{c: '{v: 1'b1, p: '0}, bef: 1'b0};
      end else begin
        prev_l[i] = links[i-1];
      end
      if (i == MAX_PER_LINE - 1) begin
        next_c[i] = '0;
      end else begin
        next_c[i] = links[i+1].c;
      end
    end
  end

  for (genvar g = 0; g < MAX_PER_LINE; g++) begin : g_cell
    ssel_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .clear    (clear),
      .ins      (ins),
      .shl      (shl),
      .classic  (!color_mode),
      .new_pick (new_pick),
      .prev     (prev_l[g]),
      .next     (next_c[g]),
      .own      (links[g])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (command.operation)
            OP_READ: state_next = S_READ;
            OP_SCAN: state_next = S_SCAN;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_READ: state_next = S_IDLE;
      S_SCAN: begin
        if ((pend && pend_id == ID_W'(TABLE_ENTRIES - 1)) ||
            count == CNT_W'(MAX_PER_LINE)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (count <= CNT_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign attr = links[0].c.p.attr;

  always_comb begin
    res_next = '0;
    if (state == S_READ) begin
      if (in_range_q) begin
        res_next.read_byte = r_word[8*lane +: 8];
      end
      res_next.last = 1'b1;
    end else if (count == '0) begin
      res_next.last = 1'b1;
    end else begin
      res_next.found        = 1'b1;
      res_next.sprite_index = 6'(links[0].c.p.id);
      res_next.pos_y        = links[0].c.p.y;
      res_next.pos_x        = links[0].c.p.x;
      res_next.tile_number  = links[0].c.p.tile;
      if (color_mode) begin
        res_next.attribute_bits = attr;
        res_next.palette_number = {1'b1, attr[2:0]};
      end else begin
        res_next.attribute_bits = attr & CLASSIC_MASK;
        res_next.palette_number = {3'b000, attr[4]};
      end
      res_next.last = (count == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      pend         <= 1'b0;
      count        <= '0;
      issue_id     <= '0;
    end else begin
      state        <= state_next;
      result_valid <= (state == S_READ) || (state == S_EMIT);
      pend         <= issuing;
      if (clear) begin
        count    <= '0;
        issue_id <= '0;
      end else begin
        if (issuing) begin
          issue_id <= issue_id + IC_W'(1);
        end
        if (ins) begin
          count <= count + CNT_W'(1);
        end else if (shl) begin
          count <= count - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_id <= issue_id[ID_W-1:0];
    if (accept) begin
      line       <= command.line_number;
      lane       <= command.table_offset[1:0];
      in_range_q <= in_range;
    end
    if ((state == S_READ) || (state == S_EMIT)) begin
      result <= res_next;
    end
  end

endmodule

>>> tb/scanline_sprite_select_top_tb.sv
module scanline_sprite_select_top_tb import ssel_pkg::*; ();

  localparam int          LIMIT_CYCLES    = 200000;
  localparam int          DRAIN_CYCLES    = 64;
  localparam int          REPORT_MAX      = 10;
  localparam logic [2:0]  ADDR_COLOR_MODE = 3'd0;
  localparam logic [2:0]  ADDR_TALL       = 3'd4;

  class sprite_scoreboard;
    logic [7:0] oam_bytes [TABLE_BYTES];
    logic       color_mode;
    logic       tall_sprites;
    result_t    pending_results [$];
    int         errors;

    function new();
      foreach (oam_bytes[i]) oam_bytes[i] = '0;
      color_mode   = 1'b0;
      tall_sprites = 1'b0;
      errors       = 0;
    endfunction

    function void queue_result(result_t r);
      pending_results.insert(pending_results.size(), r);
    endfunction

    function string fmt_result(result_t r);
      return $sformatf("rb=%h found=%b id=%0d y=%h x=%h tile=%h attr=%h pal=%h last=%b",
                       r.read_byte, r.found, r.sprite_index, r.pos_y, r.pos_x,
                       r.tile_number, r.attribute_bits, r.palette_number, r.last);
    endfunction

    function bit x_before(int a, int b);
      if (oam_bytes[4*a+1] == oam_bytes[4*b+1]) return a < b;
      return oam_bytes[4*a+1] < oam_bytes[4*b+1];
    endfunction

    function void predict_scan(logic [7:0] line);
      int         picks [MAX_PER_LINE];
      int         n;
      int         height;
      int         diff;
      int         v;
      int         j;
      logic [7:0] attr;
      result_t    r;
      n = 0;
      height = tall_sprites ? 16 : 8;
      for (int id = 0; id < TABLE_ENTRIES && n < MAX_PER_LINE; id++) begin
        diff = int'(line) - (int'(oam_bytes[4*id]) - 16);
        if (diff >= 0 && diff < height) begin
          picks[n] = id;
          n++;
        end
      end
      if (!color_mode) begin
        for (int i = 1; i < n; i++) begin
          v = picks[i];
          j = i;
          while (j > 0 && x_before(v, picks[j-1])) begin
            picks[j] = picks[j-1];
            j--;
          end
          picks[j] = v;
        end
      end
      if (n == 0) begin
        r = '0;
        r.last = 1'b1;
        queue_result(r);
      end
      for (int i = 0; i < n; i++) begin
        r = '0;
        attr = oam_bytes[4*picks[i]+3];
        if (color_mode) begin
          r.palette_number = 4'd8 + {1'b0, attr[2:0]};
        end else begin
          attr = attr & CLASSIC_MASK;
          r.palette_number = {3'b000, attr[4]};
        end
        r.found          = 1'b1;
        r.sprite_index   = 6'(picks[i]);
        r.pos_y          = oam_bytes[4*picks[i]];
        r.pos_x          = oam_bytes[4*picks[i]+1];
        r.tile_number    = oam_bytes[4*picks[i]+2];
        r.attribute_bits = attr;
        r.last           = (i == n - 1);
        queue_result(r);
      end
    endfunction

    function void note_command(cmd_t c);
      result_t r;
      case (c.operation)
        OP_READ: begin
          r = '0;
          if (c.table_offset < TABLE_BYTES) r.read_byte = oam_bytes[c.table_offset];
          r.last = 1'b1;
          queue_result(r);
        end
        OP_WRITE: begin
          if (c.table_offset < TABLE_BYTES) oam_bytes[c.table_offset] = c.write_byte;
        end
        OP_SCAN: predict_scan(c.line_number);
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX) $display("unexpected result: %s", fmt_result(got));
        return;
      end
      want = pending_results.pop_front();
      if (got.read_byte !== want.read_byte || got.found !== want.found ||
          got.sprite_index !== want.sprite_index || got.pos_y !== want.pos_y ||
          got.pos_x !== want.pos_x || got.tile_number !== want.tile_number ||
          got.attribute_bits !== want.attribute_bits ||
          got.palette_number !== want.palette_number || got.last !== want.last) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("mismatch: expected %s", fmt_result(want));
          $display("          actual   %s", fmt_result(got));
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  cmd_t        command;
  logic        result_valid;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sprite_scoreboard sb;
  int               cycles = 0;

  scanline_sprite_select_top u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .result_valid (result_valid),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(result);
  end

  function cmd_t make_cmd(op_t op, int off, int wb, int line);
    cmd_t c;
    c.operation    = op;
    c.table_offset = 8'(off);
    c.write_byte   = 8'(wb);
    c.line_number  = 8'(line);
    return c;
  endfunction

  // start stays high between back-to-back transactions
  task send_command(cmd_t c, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    command <= c;
    do @(posedge clk); while (busy);
    sb.note_command(c);
  endtask

  task drain();
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task set_mode(logic cm, logic tall);
    apb_write(ADDR_COLOR_MODE, {31'd0, cm});
    sb.color_mode = cm;
    apb_write(ADDR_TALL, {31'd0, tall});
    sb.tall_sprites = tall;
  endtask

  function cmd_t random_cmd(logic [7:0] base);
    cmd_t c;
    int   pick;
    c = make_cmd(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      c.operation = OP_WRITE;
      c.table_offset = ($urandom_range(0, 99) < 90) ? 8'($urandom_range(0, TABLE_BYTES - 1))
                                                    : 8'($urandom_range(TABLE_BYTES, 255));
      if (c.table_offset[1:0] == 2'd0 && $urandom_range(0, 1))
        c.write_byte = 8'(base + $urandom_range(16, 32));
    end else if (pick < 55) begin
      c.operation = OP_READ;
      if ($urandom_range(0, 9) == 0) c.table_offset = 8'($urandom_range(TABLE_BYTES, 255));
    end else if (pick < 95) begin
      c.operation = OP_SCAN;
      if ($urandom_range(0, 4) != 0) c.line_number = 8'(base + $urandom_range(0, 24));
    end
    return c;
  endfunction

  logic [7:0] base;
  logic [1:0] mode_bits;
  int         gap;

  initial begin
    sb      = new();
    rst     <= 1'b1;
    start   <= 1'b0;
    command <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: cleared table, bounds, ignored ops, x tie
    send_command(make_cmd(OP_READ, 0, 0, 0), 0);
    send_command(make_cmd(OP_READ, TABLE_BYTES - 1, 0, 0), 1);
    send_command(make_cmd(OP_READ, TABLE_BYTES, 0, 0), 0);
    send_command(make_cmd(OP_READ, 255, 255, 255), 3);
    send_command(make_cmd(OP_NONE, 255, 255, 255), 0);
    send_command(make_cmd(OP_SCAN, 0, 0, 0), 0);
    send_command(make_cmd(OP_WRITE, 0, 16, 0), 2);
    send_command(make_cmd(OP_WRITE, 1, 255, 0), 0);
    send_command(make_cmd(OP_WRITE, 2, 255, 0), 0);
    send_command(make_cmd(OP_WRITE, 3, 255, 0), 5);
    send_command(make_cmd(OP_WRITE, 200, 170, 0), 0);
    send_command(make_cmd(OP_READ, 200, 0, 0), 0);
    send_command(make_cmd(OP_WRITE, 156, 8'h17, 0), 0);
    send_command(make_cmd(OP_WRITE, 157, 255, 0), 1);
    send_command(make_cmd(OP_WRITE, 158, 8'h5A, 0), 0);
    send_command(make_cmd(OP_WRITE, 159, 8'h10, 0), 0);
    send_command(make_cmd(OP_SCAN, 0, 0, 0), 0);
    send_command(make_cmd(OP_SCAN, 0, 0, 7), 4);
    send_command(make_cmd(OP_SCAN, 0, 0, 255), 0);
    send_command(make_cmd(OP_READ, 3, 0, 0), 0);
    send_command(make_cmd(OP_READ, 159, 0, 0), 0);
    drain();
    set_mode(1'b1, 1'b0);
    send_command(make_cmd(OP_SCAN, 0, 0, 7), 0);
    send_command(make_cmd(OP_SCAN, 0, 0, 8), 0);

    for (int phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0: mode_bits = 2'b01;
        1: mode_bits = 2'b10;
        2: mode_bits = 2'b11;
        3: mode_bits = 2'b00;
        default: mode_bits = 2'($urandom_range(0, 3));
      endcase
      set_mode(mode_bits[1], mode_bits[0]);
      base = 8'($urandom_range(0, 255));
      // cluster sprite y values around the lines this phase scans
      for (int k = 0; k < 14; k++) begin
        gap = $urandom_range(0, 19);
        send_command(make_cmd(OP_WRITE, 4 * $urandom_range(0, TABLE_ENTRIES - 1),
                              base + $urandom_range(16, 32), $urandom_range(0, 255)), gap);
      end
      for (int k = 0; k < 16; k++) begin
        gap = $urandom_range(0, 19);
        send_command(random_cmd(base), gap);
      end
    end
    drain();

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
